### hw/rtl/a2ab_pkg.sv
// ----------------------------------------------------------------------------
// a2ab_pkg
// Shared types and constants of the AVC record / packet to Annex B converter.
// ----------------------------------------------------------------------------
`default_nettype none

package a2ab_pkg;

  // parameter-set store geometry
  localparam int PS_DEPTH = 56;
  localparam int PS_AW    = $clog2(PS_DEPTH);
  localparam int PS_LW    = $clog2(PS_DEPTH + 1);

  // error codes carried on error_code
  localparam logic [2:0] ERR_NONE      = 3'd0;
  localparam logic [2:0] ERR_LEN_TRUNC = 3'd1;
  localparam logic [2:0] ERR_NAL       = 3'd2;
  localparam logic [2:0] ERR_RECORD    = 3'd3;
  localparam logic [2:0] ERR_OVERFLOW  = 3'd4;

  // configuration record parser phase
  typedef enum logic [3:0] {
    RP_HEADER    = 4'd0,
    RP_LENSIZE   = 4'd1,
    RP_SPS_COUNT = 4'd2,
    RP_S_HI      = 4'd3,
    RP_S_LO      = 4'd4,
    RP_S_DATA    = 4'd5,
    RP_PPS_COUNT = 4'd6,
    RP_P_HI      = 4'd7,
    RP_P_LO      = 4'd8,
    RP_P_DATA    = 4'd9,
    RP_DONE      = 4'd10,
    RP_DROP      = 4'd11
  } rec_phase_e;

  // packet parser phase
  typedef enum logic [1:0] {
    PP_LENGTH = 2'd0,
    PP_FIRST  = 2'd1,
    PP_REST   = 2'd2,
    PP_DROP   = 2'd3
  } pkt_phase_e;

  // sequencer state
  typedef enum logic [2:0] {
    ST_IDLE     = 3'd0,
    ST_SCWR     = 3'd1,
    ST_PREFETCH = 3'd2,
    ST_REPLAY   = 3'd3,
    ST_START    = 3'd4
  } ctl_state_e;

  // one store entry: byte plus start-code mark
  typedef struct packed {
    logic       mark;
    logic [7:0] data;
  } ps_entry_t;

  typedef struct packed {
    logic             we;
    logic [PS_AW-1:0] addr;
    ps_entry_t        entry;
  } ps_wr_t;

  typedef struct packed {
    logic             re;
    logic [PS_AW-1:0] addr;
  } ps_rd_t;

endpackage

`default_nettype wire

### hw/rtl/a2ab_ps_store.sv
// ----------------------------------------------------------------------------
// a2ab_ps_store
// Parameter-set store: one write port, one read port, registered read data.
// ----------------------------------------------------------------------------
`default_nettype none

module a2ab_ps_store (
  input  logic                clk_i,
  input  a2ab_pkg::ps_wr_t    wr_i,
  input  a2ab_pkg::ps_rd_t    rd_i,
  output a2ab_pkg::ps_entry_t rdata_o
);
  import a2ab_pkg::*;

  ps_entry_t mem_q [PS_DEPTH];
  ps_entry_t rdata_q;

  always_ff @(posedge clk_i) begin
    if (wr_i.we) begin
      mem_q[wr_i.addr] <= wr_i.entry;
    end
  end

  // read data holds while no read is issued
  always_ff @(posedge clk_i) begin
    if (rd_i.re) begin
      rdata_q <= mem_q[rd_i.addr];
    end
  end

  assign rdata_o = rdata_q;

endmodule

`default_nettype wire

### hw/rtl/avcc_to_annexb_converter.sv
// ----------------------------------------------------------------------------
// avcc_to_annexb_converter
// Parses avcC record bytes into a parameter-set store and turns length-
// prefixed packet bytes into an Annex B stream, replaying SPS/PPS before IDR.
// ----------------------------------------------------------------------------
// One input byte is taken per cycle, while the output is not stalled, when it
// causes at most one output byte: record bytes, length bytes and NAL bytes
// after the first. A NAL's first byte is decoded, then sent as 00 00 01 plus
// the byte, a zero NAL length is decoded, then sent as 00 00 01, and on an IDR
// with a valid store the stored bytes go first, after a prefetch, one store
// read per output byte through the single read port. The low length byte of
// each record unit is followed by the writing of the start code 00 00 00 01
// to the store through its single write port. An input register and an output
// register part the two channels; output stall holds the sequencer.
// Store entries are read only below the stored length, so no clearing pass
// follows reset.
`default_nettype none

module avcc_to_annexb_converter (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       in_valid_i,
  output logic       in_stall_o,
  input  logic       command_i,
  input  logic [7:0] data_byte_i,
  input  logic       block_end_i,
  output logic       out_valid_o,
  input  logic       out_stall_i,
  output logic [7:0] out_byte_o,
  output logic       unit_start_o,
  output logic [2:0] error_code_o,
  output logic       run_last_o
);
  import a2ab_pkg::*;

  // input register
  logic       item_valid_q;
  logic       item_cmd_q;
  logic [7:0] item_byte_q;
  logic       item_end_q;
  logic       retire;

  // record parser state
  rec_phase_e       rec_phase_q, rec_phase_d;
  logic [4:0]       rec_units_q, rec_units_d;
  logic [15:0]      rec_bytes_q, rec_bytes_d;
  logic [PS_LW-1:0] plen_q, plen_d;
  logic             pvalid_q, pvalid_d;

  // packet parser state
  pkt_phase_e  pkt_phase_q, pkt_phase_d;
  logic [31:0] len_acc_q, len_acc_d;
  logic [1:0]  len_cnt_q, len_cnt_d;
  logic [31:0] nal_rem_q, nal_rem_d;

  // sequencer
  ctl_state_e       state_q, state_d;
  logic [1:0]       sc_idx_q, sc_idx_d;
  logic             with_byte_q, with_byte_d;
  logic [PS_AW-1:0] rp_idx_q, rp_idx_d;
  logic [1:0]       wcnt_q, wcnt_d;
  logic [PS_AW-1:0] sc_base_q, sc_base_d;

  // output register
  logic       out_valid_q;
  logic [7:0] out_byte_q;
  logic       unit_start_q;
  logic [2:0] error_code_q;
  logic       run_last_q;
  logic       out_free;
  logic       emit;
  logic [7:0] e_byte;
  logic       e_us;
  logic [2:0] e_err;
  logic       e_last;

  // store ports
  ps_wr_t    ps_wr;
  ps_rd_t    ps_rd;
  ps_entry_t ps_rdata;

  // record candidate
  rec_phase_e       rc_phase;
  logic [4:0]       rc_units;
  logic [15:0]      rc_bytes;
  logic [PS_LW-1:0] rc_plen;
  logic             rc_pvalid;
  logic [2:0]       rc_err;
  logic             rc_sc;
  logic             rc_we;
  logic             rc_next;
  logic             rc_pps;
  logic [15:0]      rc_len;
  logic [16:0]      rc_sum;

  // packet candidate
  pkt_phase_e  pc_phase;
  logic [31:0] pc_acc;
  logic [31:0] pc_acc_sh;
  logic [1:0]  pc_cnt;
  logic [31:0] pc_rem;
  logic [2:0]  pc_err;
  logic        pc_start;
  logic        pc_with_byte;
  logic        pc_replay;
  logic        pc_byte;

  assign out_free   = !out_valid_q || !out_stall_i;
  assign in_stall_o = item_valid_q && !retire;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      item_valid_q <= 1'b0;
    end else if (in_valid_i && !in_stall_o) begin
      item_valid_q <= 1'b1;
    end else if (retire) begin
      item_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_valid_i && !in_stall_o) begin
      item_cmd_q  <= command_i;
      item_byte_q <= data_byte_i;
      item_end_q  <= block_end_i;
    end
  end

  // record byte: next parser state and its one possible result
  always_comb begin
    rc_phase  = rec_phase_q;
    rc_units  = rec_units_q;
    rc_bytes  = rec_bytes_q;
    rc_plen   = plen_q;
    rc_pvalid = pvalid_q;
    rc_err    = ERR_NONE;
    rc_sc     = 1'b0;
    rc_we     = 1'b0;
    rc_next   = 1'b0;
    rc_pps    = 1'b0;
    rc_len    = {rec_bytes_q[7:0], item_byte_q};
    rc_sum    = 17'(plen_q) + 17'd4 + 17'(rc_len);
    case (rec_phase_q)
      RP_HEADER: begin
        if (rec_bytes_q == 16'd0) begin
          rc_pvalid = 1'b0;
          rc_plen   = '0;
        end
        rc_bytes = rec_bytes_q + 16'd1;
        if (rc_bytes >= 16'd4) begin
          rc_bytes = '0;
          rc_phase = RP_LENSIZE;
        end
      end
      RP_LENSIZE: begin
        rc_phase = RP_SPS_COUNT;
      end
      RP_SPS_COUNT: begin
        rc_units = item_byte_q[4:0];
        rc_next  = 1'b1;
      end
      RP_PPS_COUNT: begin
        rc_units = item_byte_q[4:0];
        rc_pps   = 1'b1;
        rc_next  = 1'b1;
      end
      RP_S_HI: begin
        rc_bytes = {8'd0, item_byte_q};
        rc_phase = RP_S_LO;
      end
      RP_P_HI: begin
        rc_bytes = {8'd0, item_byte_q};
        rc_phase = RP_P_LO;
      end
      RP_S_LO, RP_P_LO: begin
        rc_pps = (rec_phase_q == RP_P_LO);
        if (rc_sum > 17'(PS_DEPTH)) begin
          rc_err   = ERR_OVERFLOW;
          rc_phase = RP_DROP;
        end else begin
          rc_sc    = 1'b1;
          rc_plen  = plen_q + PS_LW'(4);
          rc_bytes = rc_len;
          if (rc_len == 16'd0) begin
            rc_next = 1'b1;
          end else begin
            rc_phase = rc_pps ? RP_P_DATA : RP_S_DATA;
          end
        end
      end
      RP_S_DATA, RP_P_DATA: begin
        rc_pps = (rec_phase_q == RP_P_DATA);
        if (plen_q < PS_LW'(PS_DEPTH)) begin
          rc_we   = 1'b1;
          rc_plen = plen_q + PS_LW'(1);
        end
        if (rec_bytes_q != 16'd0) begin
          rc_bytes = rec_bytes_q - 16'd1;
        end
        if (rc_bytes == 16'd0) begin
          rc_next = 1'b1;
        end
      end
      default: begin
      end
    endcase
    // advance to the next unit, or to the PPS count, or finish the record
    if (rc_next) begin
      if (rc_units == 5'd0) begin
        if (rc_pps) begin
          rc_phase  = RP_DONE;
          rc_pvalid = 1'b1;
        end else begin
          rc_phase = RP_PPS_COUNT;
        end
      end else begin
        rc_units = rc_units - 5'd1;
        rc_phase = rc_pps ? RP_P_HI : RP_S_HI;
      end
    end
    if (item_end_q) begin
      if (rc_phase != RP_DONE && rc_phase != RP_DROP) begin
        rc_err = ERR_RECORD;
      end
      rc_phase = RP_HEADER;
      rc_bytes = '0;
      rc_units = '0;
    end
  end

  // packet byte: next parser state and what it emits
  always_comb begin
    pc_phase     = pkt_phase_q;
    pc_acc       = len_acc_q;
    pc_acc_sh    = {len_acc_q[23:0], item_byte_q};
    pc_cnt       = len_cnt_q;
    pc_rem       = nal_rem_q;
    pc_err       = ERR_NONE;
    pc_start     = 1'b0;
    pc_with_byte = 1'b0;
    pc_replay    = 1'b0;
    pc_byte      = 1'b0;
    case (pkt_phase_q)
      PP_LENGTH: begin
        pc_acc = pc_acc_sh;
        pc_cnt = len_cnt_q + 2'd1;
        if (pc_cnt != 2'd0) begin
          if (item_end_q) begin
            pc_err = ERR_LEN_TRUNC;
          end
        end else begin
          if (pc_acc_sh[31]) begin
            pc_err   = ERR_NAL;
            pc_phase = PP_DROP;
          end else if (pc_acc_sh == 32'd0) begin
            pc_start = 1'b1;
          end else if (item_end_q) begin
            pc_err = ERR_NAL;
          end else begin
            pc_rem   = pc_acc_sh;
            pc_phase = PP_FIRST;
          end
          pc_acc = '0;
        end
      end
      PP_FIRST, PP_REST: begin
        if (item_end_q && nal_rem_q > 32'd1) begin
          pc_err = ERR_NAL;
        end else begin
          if (pkt_phase_q == PP_FIRST) begin
            pc_start     = 1'b1;
            pc_with_byte = 1'b1;
            pc_replay    = (item_byte_q[4:0] == 5'd5) && pvalid_q && (plen_q != '0);
          end else begin
            pc_byte = 1'b1;
          end
          pc_rem   = nal_rem_q - 32'd1;
          pc_phase = (pc_rem == 32'd0) ? PP_LENGTH : PP_REST;
        end
      end
      default: begin
      end
    endcase
    if (item_end_q) begin
      pc_phase = PP_LENGTH;
      pc_acc   = '0;
      pc_cnt   = '0;
      pc_rem   = '0;
    end
  end

  // sequencer: commits parser state, drives the store and the output register
  always_comb begin
    state_d     = state_q;
    rec_phase_d = rec_phase_q;
    rec_units_d = rec_units_q;
    rec_bytes_d = rec_bytes_q;
    plen_d      = plen_q;
    pvalid_d    = pvalid_q;
    pkt_phase_d = pkt_phase_q;
    len_acc_d   = len_acc_q;
    len_cnt_d   = len_cnt_q;
    nal_rem_d   = nal_rem_q;
    sc_idx_d    = sc_idx_q;
    with_byte_d = with_byte_q;
    rp_idx_d    = rp_idx_q;
    wcnt_d      = wcnt_q;
    sc_base_d   = sc_base_q;
    retire      = 1'b0;
    emit        = 1'b0;
    e_byte      = 8'd0;
    e_us        = 1'b0;
    e_err       = ERR_NONE;
    e_last      = 1'b0;
    ps_wr.we          = 1'b0;
    ps_wr.addr        = PS_AW'(plen_q);
    ps_wr.entry.mark  = 1'b0;
    ps_wr.entry.data  = item_byte_q;
    ps_rd.re          = 1'b0;
    ps_rd.addr        = '0;
    case (state_q)
      ST_IDLE: begin
        if (item_valid_q && !item_cmd_q) begin
          if (rc_err == ERR_NONE || out_free) begin
            retire      = 1'b1;
            rec_phase_d = rc_phase;
            rec_units_d = rc_units;
            rec_bytes_d = rc_bytes;
            plen_d      = rc_plen;
            pvalid_d    = rc_pvalid;
            ps_wr.we    = rc_we;
            if (rc_err != ERR_NONE) begin
              emit   = 1'b1;
              e_err  = rc_err;
              e_last = 1'b1;
            end
            if (rc_sc) begin
              sc_base_d = PS_AW'(plen_q);
              wcnt_d    = '0;
              state_d   = ST_SCWR;
            end
          end
        end else if (item_valid_q) begin
          if ((pc_err == ERR_NONE && !pc_byte) || out_free) begin
            pkt_phase_d = pc_phase;
            len_acc_d   = pc_acc;
            len_cnt_d   = pc_cnt;
            nal_rem_d   = pc_rem;
            retire      = !pc_start;
            if (pc_err != ERR_NONE) begin
              emit   = 1'b1;
              e_err  = pc_err;
              e_last = 1'b1;
            end
            if (pc_byte) begin
              emit   = 1'b1;
              e_byte = item_byte_q;
              e_last = 1'b1;
            end
            if (pc_start) begin
              sc_idx_d    = '0;
              with_byte_d = pc_with_byte;
              state_d     = pc_replay ? ST_PREFETCH : ST_START;
            end
          end
        end
      end
      ST_SCWR: begin
        // start code 00 00 00 01, marked on its first byte
        ps_wr.we         = 1'b1;
        ps_wr.addr       = sc_base_q + PS_AW'(wcnt_q);
        ps_wr.entry.mark = (wcnt_q == 2'd0);
        ps_wr.entry.data = (wcnt_q == 2'd3) ? 8'd1 : 8'd0;
        wcnt_d           = wcnt_q + 2'd1;
        if (wcnt_q == 2'd3) begin
          state_d = ST_IDLE;
        end
      end
      ST_PREFETCH: begin
        ps_rd.re   = 1'b1;
        ps_rd.addr = '0;
        rp_idx_d   = '0;
        state_d    = ST_REPLAY;
      end
      ST_REPLAY: begin
        if (out_free) begin
          emit   = 1'b1;
          e_byte = ps_rdata.data;
          e_us   = ps_rdata.mark;
          if (PS_LW'(rp_idx_q) == plen_q - PS_LW'(1)) begin
            sc_idx_d = '0;
            state_d  = ST_START;
          end else begin
            ps_rd.re   = 1'b1;
            ps_rd.addr = rp_idx_q + PS_AW'(1);
            rp_idx_d   = rp_idx_q + PS_AW'(1);
          end
        end
      end
      ST_START: begin
        if (out_free) begin
          emit     = 1'b1;
          e_us     = (sc_idx_q == 2'd0);
          sc_idx_d = sc_idx_q + 2'd1;
          case (sc_idx_q)
            2'd2:    e_byte = 8'd1;
            2'd3:    e_byte = item_byte_q;
            default: e_byte = 8'd0;
          endcase
          if ((sc_idx_q == 2'd2 && !with_byte_q) || sc_idx_q == 2'd3) begin
            e_last  = 1'b1;
            retire  = 1'b1;
            state_d = ST_IDLE;
          end
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      rec_phase_q <= RP_HEADER;
      rec_units_q <= '0;
      rec_bytes_q <= '0;
      plen_q      <= '0;
      pvalid_q    <= 1'b0;
      pkt_phase_q <= PP_LENGTH;
      len_acc_q   <= '0;
      len_cnt_q   <= '0;
      nal_rem_q   <= '0;
      sc_idx_q    <= '0;
      with_byte_q <= 1'b0;
      rp_idx_q    <= '0;
      wcnt_q      <= '0;
      sc_base_q   <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      rec_phase_q <= rec_phase_d;
      rec_units_q <= rec_units_d;
      rec_bytes_q <= rec_bytes_d;
      plen_q      <= plen_d;
      pvalid_q    <= pvalid_d;
      pkt_phase_q <= pkt_phase_d;
      len_acc_q   <= len_acc_d;
      len_cnt_q   <= len_cnt_d;
      nal_rem_q   <= nal_rem_d;
      sc_idx_q    <= sc_idx_d;
      with_byte_q <= with_byte_d;
      rp_idx_q    <= rp_idx_d;
      wcnt_q      <= wcnt_d;
      sc_base_q   <= sc_base_d;
      if (emit) begin
        out_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (emit) begin
      out_byte_q   <= e_byte;
      unit_start_q <= e_us;
      error_code_q <= e_err;
      run_last_q   <= e_last;
    end
  end

  assign out_valid_o  = out_valid_q;
  assign out_byte_o   = out_byte_q;
  assign unit_start_o = unit_start_q;
  assign error_code_o = error_code_q;
  assign run_last_o   = run_last_q;

  // one item in flight: store writes always finish before any replay read
  a2ab_ps_store u_ps_store (
    .clk_i   (clk_i),
    .wr_i    (ps_wr),
    .rd_i    (ps_rd),
    .rdata_o (ps_rdata)
  );

`ifndef SYNTH
  a_plen_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    plen_q <= PS_LW'(PS_DEPTH))
    else $error("stored length beyond store depth");

  a_replay_idx: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == ST_REPLAY |-> PS_LW'(rp_idx_q) < plen_q)
    else $error("replay index beyond stored length");

  a_err_clean: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && error_code_o != ERR_NONE |-> out_byte_o == 8'd0 && !unit_start_o)
    else $error("error transaction carries stream data");

  a_retire_item: assert property (@(posedge clk_i) disable iff (!rst_ni)
    retire |-> item_valid_q)
    else $error("retire without an item");

  a_prefetch: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == ST_PREFETCH |=> state_q == ST_REPLAY)
    else $error("prefetch not followed by replay");
`endif

endmodule

`default_nettype wire

### verif/avcc_to_annexb_converter_tb.sv
// ----------------------------------------------------------------------------
// avcc_to_annexb_converter_tb
// Feeds avcC record bytes and length-prefixed packet bytes through the
// converter with random input gaps and output stalls. A behavioral model of
// the parser predicts every Annex B byte and error; each output transaction is
// checked in order, field by field.
// ----------------------------------------------------------------------------
module avcc_to_annexb_converter_tb;
  timeunit 1ns;
  timeprecision 1ps;

  import a2ab_pkg::*;

  localparam logic       CMD_RECORD   = 1'b0;
  localparam logic       CMD_PACKET   = 1'b1;
  localparam logic [4:0] NAL_IDR      = 5'd5;
  localparam int         RAND_ITEMS   = 220;
  localparam int         DRAIN_CYCLES = 100;
  localparam int         LIMIT_CYCLES = 500000;

  typedef struct packed {
    logic       cmd;
    logic [7:0] data;
    logic       last;
  } feed_t;

  typedef struct packed {
    logic [7:0] data;
    logic       start;
    logic [2:0] err;
    logic       last;
  } annexb_t;

  logic       clk_i        = 1'b0;
  logic       rst_ni       = 1'b0;
  logic       in_valid_i   = 1'b0;
  logic       in_stall_o;
  logic       command_i    = CMD_RECORD;
  logic [7:0] data_byte_i  = 8'h00;
  logic       block_end_i  = 1'b0;
  logic       out_valid_o;
  logic       out_stall_i  = 1'b0;
  logic [7:0] out_byte_o;
  logic       unit_start_o;
  logic [2:0] error_code_o;
  logic       run_last_o;

  feed_t   pending[$];
  feed_t   blk_q[$];
  annexb_t annexb_q[$];
  logic    idle_en = 1'b1;
  int      in_gap = 0;
  int      stall_left = 0;
  int      mismatches = 0;
  int      cycle_count = 0;

  // converter state as the model tracks it
  logic [7:0]          ps_mem [PS_DEPTH];
  logic [PS_DEPTH-1:0] ps_mark   = '0;
  logic [PS_LW-1:0]    ps_len    = '0;
  logic                ps_valid  = 1'b0;
  rec_phase_e          rec_ph    = RP_HEADER;
  logic [4:0]          rec_units = '0;
  logic [15:0]         rec_left  = '0;
  pkt_phase_e          pkt_ph    = PP_LENGTH;
  logic [31:0]         len_acc   = '0;
  logic [1:0]          len_cnt   = '0;
  logic [31:0]         nal_left  = '0;

  avcc_to_annexb_converter u_top (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (in_valid_i),
    .in_stall_o   (in_stall_o),
    .command_i    (command_i),
    .data_byte_i  (data_byte_i),
    .block_end_i  (block_end_i),
    .out_valid_o  (out_valid_o),
    .out_stall_i  (out_stall_i),
    .out_byte_o   (out_byte_o),
    .unit_start_o (unit_start_o),
    .error_code_o (error_code_o),
    .run_last_o   (run_last_o)
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  // ---------------------------------------------------------------- model

  function automatic void emit(input logic [7:0] b, input logic sc, input logic [2:0] err);
    annexb_t r;
    r = '{data: b, start: sc, err: err, last: 1'b0};
    annexb_q.push_back(r);
  endfunction

  function automatic void emit_start_code();
    emit(8'h00, 1'b1, ERR_NONE);
    emit(8'h00, 1'b0, ERR_NONE);
    emit(8'h01, 1'b0, ERR_NONE);
  endfunction

  function automatic void next_unit(input logic pps);
    if (rec_units == 0) begin
      if (pps) begin
        rec_ph   = RP_DONE;
        ps_valid = 1'b1;
      end else begin
        rec_ph = RP_PPS_COUNT;
      end
    end else begin
      rec_units = rec_units - 5'd1;
      rec_ph    = pps ? RP_P_HI : RP_S_HI;
    end
  endfunction

  function automatic void parse_record_byte(input logic [7:0] b, input logic last);
    logic        pps;
    logic [15:0] ulen;
    case (rec_ph)
      RP_HEADER: begin
        // first byte of a new record drops the old parameter sets
        if (rec_left == 0) begin
          ps_valid = 1'b0;
          ps_len   = '0;
          ps_mark  = '0;
        end
        rec_left = rec_left + 16'd1;
        if (rec_left >= 16'd4) begin
          rec_left = '0;
          rec_ph   = RP_LENSIZE;
        end
      end
      RP_LENSIZE: rec_ph = RP_SPS_COUNT;
      RP_SPS_COUNT: begin
        rec_units = b[4:0];
        next_unit(1'b0);
      end
      RP_PPS_COUNT: begin
        rec_units = b[4:0];
        next_unit(1'b1);
      end
      RP_S_HI, RP_P_HI: begin
        rec_left = {8'h00, b};
        rec_ph   = (rec_ph == RP_S_HI) ? RP_S_LO : RP_P_LO;
      end
      RP_S_LO, RP_P_LO: begin
        pps  = (rec_ph == RP_P_LO);
        ulen = {rec_left[7:0], b};
        if (int'(ps_len) + 4 + int'(ulen) > PS_DEPTH) begin
          emit(8'h00, 1'b0, ERR_OVERFLOW);
          rec_ph = RP_DROP;
        end else begin
          ps_mark[ps_len]  = 1'b1;
          ps_mem[ps_len]   = 8'h00;
          ps_mem[ps_len+1] = 8'h00;
          ps_mem[ps_len+2] = 8'h00;
          ps_mem[ps_len+3] = 8'h01;
          ps_len   = ps_len + 4;
          rec_left = ulen;
          if (ulen == 0) next_unit(pps);
          else rec_ph = pps ? RP_P_DATA : RP_S_DATA;
        end
      end
      RP_S_DATA, RP_P_DATA: begin
        pps = (rec_ph == RP_P_DATA);
        if (ps_len < PS_DEPTH) begin
          ps_mem[ps_len] = b;
          ps_len = ps_len + 1;
        end
        if (rec_left > 0) rec_left = rec_left - 16'd1;
        if (rec_left == 0) next_unit(pps);
      end
      default: ;
    endcase
    if (last) begin
      if (rec_ph != RP_DONE && rec_ph != RP_DROP) emit(8'h00, 1'b0, ERR_RECORD);
      rec_ph    = RP_HEADER;
      rec_left  = '0;
      rec_units = '0;
    end
  endfunction

  function automatic void parse_packet_byte(input logic [7:0] b, input logic last);
    case (pkt_ph)
      PP_LENGTH: begin
        len_acc = {len_acc[23:0], b};
        len_cnt = len_cnt + 2'd1;
        if (len_cnt != 0) begin
          if (last) emit(8'h00, 1'b0, ERR_LEN_TRUNC);
        end else begin
          if (len_acc[31]) begin
            emit(8'h00, 1'b0, ERR_NAL);
            pkt_ph = PP_DROP;
          end else if (len_acc == 0) begin
            emit_start_code();
          end else if (last) begin
            emit(8'h00, 1'b0, ERR_NAL);
          end else begin
            nal_left = len_acc;
            pkt_ph   = PP_FIRST;
          end
          len_acc = '0;
        end
      end
      PP_FIRST, PP_REST: begin
        if (last && nal_left > 1) begin
          emit(8'h00, 1'b0, ERR_NAL);
        end else begin
          if (pkt_ph == PP_FIRST) begin
            // IDR slice: replay stored SPS/PPS first
            if (b[4:0] == NAL_IDR && ps_valid) begin
              for (int i = 0; i < ps_len; i++) emit(ps_mem[i], ps_mark[i], ERR_NONE);
            end
            emit_start_code();
          end
          emit(b, 1'b0, ERR_NONE);
          nal_left = nal_left - 32'd1;
          pkt_ph   = (nal_left == 0) ? PP_LENGTH : PP_REST;
        end
      end
      default: ;
    endcase
    if (last) begin
      pkt_ph   = PP_LENGTH;
      len_acc  = '0;
      len_cnt  = '0;
      nal_left = '0;
    end
  endfunction

  function automatic void convert_byte(input logic cmd, input logic [7:0] b, input logic last);
    int      base;
    annexb_t tail;
    base = annexb_q.size();
    if (cmd == CMD_RECORD) parse_record_byte(b, last);
    else parse_packet_byte(b, last);
    if (annexb_q.size() > base) begin
      tail = annexb_q.pop_back();
      tail.last = 1'b1;
      annexb_q.push_back(tail);
    end
  endfunction

  // ------------------------------------------------------------- stimulus

  task automatic add_byte(input logic cmd, input logic [7:0] b);
    feed_t f;
    f = '{cmd: cmd, data: b, last: 1'b0};
    blk_q.push_back(f);
  endtask

  task automatic add_word(input logic cmd, input logic [31:0] w);
    for (int sh = 24; sh >= 0; sh -= 8) add_byte(cmd, w[sh+:8]);
  endtask

  // keeps the first keep bytes of the block, marks the last one as block end
  task automatic commit_block(input int keep);
    feed_t f;
    while (blk_q.size() > keep) void'(blk_q.pop_back());
    f = blk_q.pop_back();
    f.last = 1'b1;
    blk_q.push_back(f);
    foreach (blk_q[k]) pending.push_back(blk_q[k]);
    blk_q.delete();
  endtask

  task automatic add_record(input int n_sps, input int n_pps, input int max_len, input int trail);
    int units;
    int ulen;
    repeat (5) add_byte(CMD_RECORD, 8'($urandom));
    for (int s = 0; s < 2; s++) begin
      units = (s == 0) ? n_sps : n_pps;
      add_byte(CMD_RECORD, {3'($urandom), 5'(units)});
      for (int u = 0; u < units; u++) begin
        ulen = $urandom_range(0, max_len);
        add_byte(CMD_RECORD, 8'(ulen >> 8));
        add_byte(CMD_RECORD, 8'(ulen));
        // long units only occur in blocks that get cut short anyway
        repeat ((ulen > 64) ? 64 : ulen) add_byte(CMD_RECORD, 8'($urandom));
      end
    end
    repeat (trail) add_byte(CMD_RECORD, 8'($urandom));
  endtask

  task automatic add_packet(input int n_nal, input int max_len);
    int         nlen;
    logic [7:0] hdr;
    for (int k = 0; k < n_nal; k++) begin
      nlen = $urandom_range(0, max_len);
      add_word(CMD_PACKET, 32'(nlen));
      if (nlen > 0) begin
        hdr = 8'($urandom);
        if ($urandom_range(0, 2) == 0) hdr[4:0] = NAL_IDR;
        add_byte(CMD_PACKET, hdr);
        repeat (nlen - 1) add_byte(CMD_PACKET, 8'($urandom));
      end
    end
  endtask

  task automatic build_stimulus();
    int base;
    int pick;
    int units;
    // one SPS of one byte, no PPS
    add_word(CMD_RECORD, 32'h0164_001F);
    add_word(CMD_RECORD, 32'hFFE1_0001);
    add_byte(CMD_RECORD, 8'h67);
    add_byte(CMD_RECORD, 8'hE0);
    commit_block(blk_q.size());
    // IDR of one byte: replays the store
    add_word(CMD_PACKET, 32'h0000_0001);
    add_byte(CMD_PACKET, 8'h25);
    commit_block(blk_q.size());
    // zero length NAL, then a length cut off after two bytes
    add_word(CMD_PACKET, 32'h0000_0000);
    add_byte(CMD_PACKET, 8'hFF);
    add_byte(CMD_PACKET, 8'hFF);
    commit_block(blk_q.size());
    // negative length, rest of packet dropped
    add_word(CMD_PACKET, 32'h8000_0000);
    add_byte(CMD_PACKET, 8'h00);
    commit_block(blk_q.size());

    base = pending.size();
    while (pending.size() - base < RAND_ITEMS) begin
      pick = $urandom_range(0, 99);
      if (pick < 20) begin
        add_record($urandom_range(1, 2), $urandom_range(1, 2), 10, $urandom_range(0, 2));
        commit_block(blk_q.size());
      end else if (pick < 26) begin
        // unit counts up to the field maximum, or long units: store overflow
        units = $urandom_range(0, 31);
        add_record(units, $urandom_range(0, 3), (units > 3) ? 0 : 24, 1);
        commit_block(blk_q.size());
      end else if (pick < 32) begin
        add_record($urandom_range(1, 2), $urandom_range(1, 2), (pick < 29) ? 10 : 65535, 0);
        commit_block($urandom_range(1, (blk_q.size() > 41) ? 40 : blk_q.size() - 1));
      end else if (pick < 80) begin
        add_packet($urandom_range(1, 3), (pick < 70) ? 6 : 20);
        commit_block(blk_q.size());
      end else if (pick < 92) begin
        if (pick < 86) begin
          add_packet($urandom_range(1, 3), 8);
        end else begin
          add_word(CMD_PACKET, 32'($urandom));
          repeat ($urandom_range(0, 10)) add_byte(CMD_PACKET, 8'($urandom));
        end
        commit_block($urandom_range(1, blk_q.size()));
      end else begin
        repeat ($urandom_range(1, 8)) add_byte(1'($urandom), 8'($urandom));
        commit_block(blk_q.size());
      end
    end
  endtask

  // -------------------------------------------------------- drive / check

  always @(posedge clk_i or negedge rst_ni) begin : feed_drv
    feed_t nxt;
    if (!rst_ni) begin
      in_valid_i <= 1'b0;
      in_gap     <= 0;
    end else if (!in_valid_i || !in_stall_o) begin
      if (in_gap != 0) begin
        in_valid_i <= 1'b0;
        in_gap     <= in_gap - 1;
      end else if (pending.size() != 0) begin
        nxt = pending.pop_front();
        in_valid_i  <= 1'b1;
        command_i   <= nxt.cmd;
        data_byte_i <= nxt.data;
        block_end_i <= nxt.last;
        if (idle_en && $urandom_range(0, 5) == 0) in_gap <= $urandom_range(1, 6);
      end else begin
        in_valid_i <= 1'b0;
      end
    end
  end

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_stall_i <= 1'b0;
      stall_left  <= 0;
    end else if (stall_left != 0) begin
      out_stall_i <= 1'b1;
      stall_left  <= stall_left - 1;
    end else if (idle_en && $urandom_range(0, 5) == 0) begin
      out_stall_i <= 1'b1;
      stall_left  <= $urandom_range(0, 5);
    end else begin
      out_stall_i <= 1'b0;
    end
  end

  always @(posedge clk_i) begin
    if (rst_ni && in_valid_i && !in_stall_o) convert_byte(command_i, data_byte_i, block_end_i);
  end

  task automatic report_mismatch(input string msg);
    $display("ERROR %0t: %s", $time, msg);
    mismatches++;
  endtask

  task automatic check_field(input string name, input logic [7:0] got, input logic [7:0] want);
    if (got !== want) report_mismatch($sformatf("%s got %0h want %0h", name, got, want));
  endtask

  always @(posedge clk_i) begin : annexb_mon
    annexb_t want;
    if (rst_ni && out_valid_o && !out_stall_i) begin
      if (annexb_q.size() == 0) begin
        report_mismatch($sformatf("unexpected transaction: byte %0h error_code %0d",
                                  out_byte_o, error_code_o));
      end else begin
        want = annexb_q.pop_front();
        check_field("out_byte", out_byte_o, want.data);
        check_field("unit_start", 8'(unit_start_o), 8'(want.start));
        check_field("error_code", 8'(error_code_o), 8'(want.err));
        check_field("run_last", 8'(run_last_o), 8'(want.last));
      end
    end
  end

  initial begin
    while (cycle_count < LIMIT_CYCLES) begin
      @(posedge clk_i);
      cycle_count++;
    end
    $display("timeout after %0d cycles", cycle_count);
    $display("avcc_to_annexb_converter_tb failed");
    $finish;
  end

  initial begin
    build_stimulus();
    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;
    // quiet tail: no gaps or stalls for the last transactions
    while (pending.size() >= 40) @(posedge clk_i);
    idle_en <= 1'b0;
    while (pending.size() != 0 || in_valid_i) @(posedge clk_i);
    while (annexb_q.size() != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
    if (mismatches == 0) begin
      $display("avcc_to_annexb_converter_tb passed");
    end else begin
      $display("avcc_to_annexb_converter_tb failed");
    end
    $finish;
  end

endmodule
